// ===== hdl/frustum_aabb_cull_defines.svh =====
// Assertion macros for the frustum box culler.
// Used by the top level; expects clk and arst_n in the including scope.
`ifndef FRUSTUM_AABB_CULL_DEFINES_SVH
`define FRUSTUM_AABB_CULL_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FAC_CHECK(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frustum_aabb_cull check failed");

// Next-cycle implication, disabled during reset.
`define FAC_CHECK_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frustum_aabb_cull check failed");

`endif

// ===== hdl/fac_pkg.sv =====
// Shared types and constants for the frustum box culler.
// No dependencies; imported by fac_cell and frustum_aabb_cull.
`default_nettype none

package fac_pkg;

	localparam int NUM_PLANES = 6;
	localparam int CELL_ID_W = 4;
	localparam int IDX_W = 3;
	localparam int NORM_W = 16;
	localparam int COORD_W = 32;
	localparam int OFFS_W = 48;
	localparam int PROD_W = NORM_W + COORD_W;
	localparam int SUM_W = PROD_W + 2;

	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_TEST = 1'b1
	} action_t;

	typedef struct packed {
		action_t action;
		logic [IDX_W-1:0] plane_index;
		logic signed [NORM_W-1:0] normal_x;
		logic signed [NORM_W-1:0] normal_y;
		logic signed [NORM_W-1:0] normal_z;
		logic signed [OFFS_W-1:0] plane_offset;
		logic signed [COORD_W-1:0] box_max_x;
		logic signed [COORD_W-1:0] box_max_y;
		logic signed [COORD_W-1:0] box_max_z;
		logic signed [COORD_W-1:0] box_min_x;
		logic signed [COORD_W-1:0] box_min_y;
		logic signed [COORD_W-1:0] box_min_z;
	} item_t;

endpackage

`default_nettype wire

// ===== hdl/frustum_aabb_cull.sv =====
// Top level of the frustum box culler: a chain of plane cells and a result register.
// Depends on fac_pkg, fac_cell and frustum_aabb_cull_defines.svh.
//
//   channel  handshake           payload
//   cmd      cmd_valid/cmd_stall action, plane_index, normal_*, plane_offset, box_*
//   rsp      rsp_valid/rsp_stall inside_res (one per test item, none per load)
//
// One item enters per cycle while cmd_stall is low; its result passes every cell stage and the result register.
// Each plane cell has two register stages: three products, then sum and compare.
// Loads travel down the chain with the tests, so every test sees the planes in item order.
// Reset clears every plane to zero, so an unloaded plane always passes.
// A stalled result freezes the whole chain and raises cmd_stall.
`default_nettype none

`include "frustum_aabb_cull_defines.svh"

module frustum_aabb_cull import fac_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	output logic                      cmd_stall,
	input  logic                      action,
	input  logic [IDX_W-1:0]          plane_index,
	input  logic signed [NORM_W-1:0]  normal_x,
	input  logic signed [NORM_W-1:0]  normal_y,
	input  logic signed [NORM_W-1:0]  normal_z,
	input  logic signed [OFFS_W-1:0]  plane_offset,
	input  logic signed [COORD_W-1:0] box_max_x,
	input  logic signed [COORD_W-1:0] box_max_y,
	input  logic signed [COORD_W-1:0] box_max_z,
	input  logic signed [COORD_W-1:0] box_min_x,
	input  logic signed [COORD_W-1:0] box_min_y,
	input  logic signed [COORD_W-1:0] box_min_z,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output logic                      inside_res
);

	logic                   adv;
	logic [NUM_PLANES:0]    node_valid;
	item_t                  node_item [NUM_PLANES+1];
	logic [NUM_PLANES:0]    node_inside;
	logic                   rsp_valid_q;
	logic                   inside_q;
	logic                   last_test;

	assign adv       = !(rsp_valid_q && rsp_stall);
	assign cmd_stall = !adv;

	always_comb begin
		node_item[0].action       = action_t'(action);
		node_item[0].plane_index  = plane_index;
		node_item[0].normal_x     = normal_x;
		node_item[0].normal_y     = normal_y;
		node_item[0].normal_z     = normal_z;
		node_item[0].plane_offset = plane_offset;
		node_item[0].box_max_x    = box_max_x;
		node_item[0].box_max_y    = box_max_y;
		node_item[0].box_max_z    = box_max_z;
		node_item[0].box_min_x    = box_min_x;
		node_item[0].box_min_y    = box_min_y;
		node_item[0].box_min_z    = box_min_z;
	end

	assign node_valid[0]  = cmd_valid;
	assign node_inside[0] = 1'b1;

	for (genvar g = 0; g < NUM_PLANES; g++) begin : g_cell
		fac_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.adv        (adv),
			.cell_id    (CELL_ID_W'(g)),
			.in_valid   (node_valid[g]),
			.in_item    (node_item[g]),
			.in_inside  (node_inside[g]),
			.out_valid  (node_valid[g+1]),
			.out_item   (node_item[g+1]),
			.out_inside (node_inside[g+1])
		);
	end

	assign last_test = node_valid[NUM_PLANES] && (node_item[NUM_PLANES].action == ACT_TEST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= last_test;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			inside_q <= node_inside[NUM_PLANES];
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign inside_res = inside_q;

	`FAC_CHECK_NEXT(a_chain_frozen, rsp_valid && rsp_stall, $stable(node_valid[NUM_PLANES:1]))
	`FAC_CHECK_NEXT(a_rsp_only_from_test, adv && !last_test, !rsp_valid)
	`FAC_CHECK_NEXT(a_rsp_held, rsp_valid && rsp_stall, rsp_valid && $stable(inside_res))

endmodule

`default_nettype wire

// ===== hdl/fac_cell.sv =====
// One plane cell of the culling chain: holds a plane and tests passing boxes.
// Depends on fac_pkg; instantiated once per plane by frustum_aabb_cull.
`default_nettype none

module fac_cell import fac_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic [CELL_ID_W-1:0] cell_id,
	input  logic                 in_valid,
	input  item_t                in_item,
	input  logic                 in_inside,
	output logic                 out_valid,
	output item_t                out_item,
	output logic                 out_inside
);

	logic signed [NORM_W-1:0]  nx_q, ny_q, nz_q;
	logic signed [OFFS_W-1:0]  off_q;
	logic                      hit;
	logic signed [COORD_W-1:0] cx, cy, cz;
	logic signed [PROD_W-1:0]  px, py, pz;

	logic                      valid_s1;
	item_t                     item_s1;
	logic                      inside_s1;
	logic signed [PROD_W-1:0]  px_s1, py_s1, pz_s1;
	logic signed [OFFS_W-1:0]  off_s1;

	logic signed [SUM_W-1:0]   sum;
	logic signed [SUM_W-1:0]   off_ext;
	logic                      pass;

	logic                      valid_s2;
	item_t                     item_s2;
	logic                      inside_s2;

	assign hit = in_valid && (in_item.action == ACT_LOAD)
		&& (CELL_ID_W'(in_item.plane_index) == cell_id);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nx_q  <= '0;
			ny_q  <= '0;
			nz_q  <= '0;
			off_q <= '0;
		end else if (adv && hit) begin
			nx_q  <= in_item.normal_x;
			ny_q  <= in_item.normal_y;
			nz_q  <= in_item.normal_z;
			off_q <= in_item.plane_offset;
		end
	end

	// A zero normal component selects the max corner.
	always_comb begin
		cx = nx_q[NORM_W-1] ? in_item.box_min_x : in_item.box_max_x;
		cy = ny_q[NORM_W-1] ? in_item.box_min_y : in_item.box_max_y;
		cz = nz_q[NORM_W-1] ? in_item.box_min_z : in_item.box_max_z;
		px = nx_q * cx;
		py = ny_q * cy;
		pz = nz_q * cz;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1   <= in_item;
			inside_s1 <= in_inside;
			px_s1     <= px;
			py_s1     <= py;
			pz_s1     <= pz;
			off_s1    <= off_q;
		end
	end

	always_comb begin
		sum = $signed({{2{px_s1[PROD_W-1]}}, px_s1})
			+ $signed({{2{py_s1[PROD_W-1]}}, py_s1})
			+ $signed({{2{pz_s1[PROD_W-1]}}, pz_s1});
		off_ext = $signed({{(SUM_W-OFFS_W){off_s1[OFFS_W-1]}}, off_s1});
		pass = (sum >= off_ext);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s2   <= item_s1;
			inside_s2 <= inside_s1 & pass;
		end
	end

	assign out_valid  = valid_s2;
	assign out_item   = item_s2;
	assign out_inside = inside_s2;

endmodule

`default_nettype wire
